/* src/kbrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrr_pkg
// Shared types and constants for the keyboard receive register.
// ----------------------------------------------------------------------------
package kbrr_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int PTR_W        = ADDR_W + 1;

  localparam logic [7:0] COUNT_MAX  = 8'hFF;
  localparam logic [7:0] ERROR_BYTE = 8'h80;
  localparam logic [4:0] REG_BYTES  = 5'd8;

  typedef enum logic [2:0] {
    MODE_KEY   = 3'd0,
    MODE_READ  = 3'd1,
    MODE_PUSH  = 3'd2,
    MODE_START = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_NO_PWR  = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  // request from the register logic to the preload buffer
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } buf_req_t;

  // buffer status seen by the register logic
  typedef struct packed {
    logic       has_byte;
    logic       full;
    logic [7:0] head;
  } buf_stat_t;

endpackage

/* src/kbrr_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbrr_buffer
// Preload buffer: byte store with read/write pointers and a prefetched head.
// ----------------------------------------------------------------------------
module kbrr_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  kbrr_pkg::buf_req_t  req,
  output kbrr_pkg::buf_stat_t stat
);

  logic [7:0] mem [kbrr_pkg::BUFFER_DEPTH];

  logic [kbrr_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kbrr_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kbrr_pkg::ADDR_W-1:0] waddr;
  logic [kbrr_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                  head_r;
  logic                        we;
  logic                        has_byte;
  logic                        full;

  assign has_byte = (rd_ptr_r < wr_ptr_r);
  assign full     = has_byte && (wr_ptr_r == kbrr_pkg::PTR_W'(kbrr_pkg::BUFFER_DEPTH));

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    waddr      = wr_ptr_r[kbrr_pkg::ADDR_W-1:0];
    we         = 1'b0;
    if (req.push) begin
      if (!has_byte) begin
        // empty buffer restarts at the bottom
        rd_ptr_nxt = '0;
        wr_ptr_nxt = kbrr_pkg::PTR_W'(1);
        waddr      = '0;
        we         = 1'b1;
      end else if (!full) begin
        wr_ptr_nxt = wr_ptr_r + kbrr_pkg::PTR_W'(1);
        we         = 1'b1;
      end
    end else if (req.pop && has_byte) begin
      rd_ptr_nxt = rd_ptr_r + kbrr_pkg::PTR_W'(1);
    end
  end

  assign raddr = rd_ptr_nxt[kbrr_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // head byte is prefetched from the next read pointer; write-through when pushing to the head slot
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= req.wdata;
    end
    if (we && (waddr == raddr)) begin
      head_r <= req.wdata;
    end else begin
      head_r <= mem[raddr];
    end
  end

  assign stat.has_byte = has_byte;
  assign stat.full     = full;
  assign stat.head     = head_r;

endmodule

/* src/keyboard_receive_register.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_receive_register
// Keyboard receive register, preload buffer, one transaction per ready cycle.
// ----------------------------------------------------------------------------
// Takes one input transaction every clock cycle while in_ready is high; each
// result appears in the output register the cycle after it is accepted. The
// input side is ready whenever the output register is empty or its result is
// taken in the same cycle. The 4096-byte preload buffer is a single-port-write
// memory whose head byte is prefetched, so a pop never stalls the input.
// The power_on register is written through the cfg_ channel, always ready.
module keyboard_receive_register (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_power_on,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_char_in,
  input  logic [2:0]  in_byte_offset,
  input  logic [3:0]  in_access_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_read_data,
  output logic        out_irq_pulse,
  output logic [1:0]  out_status
);

  kbrr_pkg::buf_req_t  buf_req;
  kbrr_pkg::buf_stat_t buf_stat;

  logic        power_on_r;
  logic        error_r, error_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  last_r, last_nxt;
  logic        out_valid_r;
  logic [63:0] out_data_r, out_data_nxt;
  logic        out_irq_r, out_irq_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        accept;
  logic [63:0] image;
  logic [7:0]  count_inc;
  logic [4:0]  read_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  assign image     = {(error_r ? kbrr_pkg::ERROR_BYTE : 8'h00), 16'h0, count_r, 24'h0, last_r};
  assign count_inc = (count_r == kbrr_pkg::COUNT_MAX) ? count_r : count_r + 8'd1;
  assign read_end  = {2'b00, in_byte_offset} + {1'b0, in_access_size};

  kbrr_buffer u_buffer (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (buf_req),
    .stat  (buf_stat)
  );

  always_comb begin
    error_nxt      = error_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    out_data_nxt   = '0;
    out_irq_nxt    = 1'b0;
    out_status_nxt = kbrr_pkg::ST_OK;
    buf_req.push   = 1'b0;
    buf_req.pop    = 1'b0;
    buf_req.wdata  = in_char_in;
    if (accept) begin
      unique case (kbrr_pkg::mode_t'(in_mode))
        kbrr_pkg::MODE_KEY: begin
          if (buf_stat.has_byte) begin
            out_status_nxt = kbrr_pkg::ST_BUSY;
          end else if (!power_on_r) begin
            out_status_nxt = kbrr_pkg::ST_NO_PWR;
          end else begin
            last_nxt    = in_char_in;
            count_nxt   = count_inc;
            error_nxt   = error_r || (count_inc > 8'd1);
            out_irq_nxt = 1'b1;
          end
        end
        kbrr_pkg::MODE_READ: begin
          out_data_nxt = image << {in_byte_offset, 3'b000};
          if (read_end >= kbrr_pkg::REG_BYTES) begin
            error_nxt = 1'b0;
            count_nxt = '0;
            last_nxt  = '0;
            if (buf_stat.has_byte) begin
              buf_req.pop = 1'b1;
              last_nxt    = buf_stat.head;
              count_nxt   = 8'd1;
              out_irq_nxt = 1'b1;
            end
          end
        end
        kbrr_pkg::MODE_PUSH: begin
          buf_req.push = 1'b1;
          if (buf_stat.full) begin
            out_status_nxt = kbrr_pkg::ST_DROPPED;
          end
        end
        kbrr_pkg::MODE_START: begin
          if (buf_stat.has_byte) begin
            buf_req.pop = 1'b1;
            last_nxt    = buf_stat.head;
            count_nxt   = count_inc;
            error_nxt   = error_r || (count_inc > 8'd1);
            out_irq_nxt = 1'b1;
          end
        end
        kbrr_pkg::MODE_CLEAR: begin
          error_nxt = 1'b0;
          count_nxt = '0;
          last_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r  <= 1'b0;
      error_r     <= 1'b0;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        power_on_r <= cfg_power_on;
      end
      error_r <= error_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_irq_r    <= out_irq_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq_pulse = out_irq_r;
  assign out_status    = out_status_r;

endmodule
